[rtl/owk_pkg.sv]
// Shared types, constants and the control program of the omni-wheel kinematics core.
// Holds the control word layout and the microcode table read by owk_sequencer.
// No dependencies.
package owk_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DT_FRAC = 16;
    localparam int K_SHIFT = 30;
    localparam int IN_W = 112;
    localparam int OUT_W = 128;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W = 33;

    // Geometric constants with 30 fraction bits. Cosine of 30 degrees equals sine of
    // 60 degrees and sine of 30 degrees equals cosine of 60 degrees, so two serve all.
    localparam logic [29:0] K_COS45 = 30'd759250125;
    localparam logic [29:0] K_SIN60 = 30'd929887697;
    localparam logic [29:0] K_COS60 = 30'd536870912;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RPM = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = CFG_IDX_W'(3);

    localparam int PROG_LEN = 47;
    localparam int PC_W = $clog2(PROG_LEN);
    localparam logic [PC_W-1:0] PC_THREE = PC_W'(28);

    typedef enum logic [2:0] {
        MA_NONE, MA_ACCEL, MA_TWZ, MA_LVX, MA_LVY, MA_MAGLO, MA_MAGHI
    } mula_t;

    typedef enum logic [2:0] {
        MB_DT, MB_DT5, MB_RADIUS, MB_COS45, MB_SIN60, MB_COS60, MB_RPM
    } mulb_t;

    typedef enum logic [2:0] {
        D_NONE, D_STEPX, D_STEPY, D_WR, D_TX, D_TY, D_SC
    } dst_t;

    typedef enum logic [1:0] {
        SH_DTX, SH_DTY, SH_FRAC, SH_K
    } sh_t;

    typedef enum logic [2:0] {
        A_NOP, A_SLEWX, A_SLEWY, A_SUM, A_ABS, A_SAT, A_ZERO
    } alu_t;

    typedef enum logic [1:0] {
        T_OFF, T_ADD, T_SUB, T_VX
    } tsel_t;

    typedef enum logic [1:0] {
        J_NEXT, J_THREE, J_FIN
    } jmp_t;

    typedef struct packed {
        mula_t           mul_a;
        mulb_t           mul_b;
        dst_t            shr_dst;
        sh_t             shr_sh;
        alu_t            alu_op;
        tsel_t           tx_sel;
        tsel_t           ty_sel;
        logic [1:0]      wheel;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
    } owk_ctrl_t;

    typedef struct packed {
        logic      run;
        logic      load;
        logic      fin;
        owk_ctrl_t ctrl;
    } owk_seq_t;

    localparam owk_ctrl_t CW_NOP = '{
        mul_a: MA_NONE, mul_b: MB_DT, shr_dst: D_NONE, shr_sh: SH_DTX,
        alu_op: A_NOP, tx_sel: T_OFF, ty_sel: T_OFF, wheel: 2'd0,
        jmp: J_NEXT, target: '0
    };

    function automatic owk_ctrl_t cw(input mula_t ma, input mulb_t mb, input dst_t dst,
                                     input sh_t sh, input alu_t alu, input jmp_t jmp);
        owk_ctrl_t w;
        w = CW_NOP;
        w.mul_a = ma;
        w.mul_b = mb;
        w.shr_dst = dst;
        w.shr_sh = sh;
        w.alu_op = alu;
        w.jmp = jmp;
        return w;
    endfunction

    // One wheel takes five steps: sum, magnitude, low and high partial products, saturate.
    function automatic owk_ctrl_t owk_wheel(input int ph, input logic [1:0] k,
                                            input tsel_t tx, input tsel_t ty);
        owk_ctrl_t w;
        w = CW_NOP;
        w.wheel = k;
        unique case (ph)
            0:
            begin
                w.alu_op = A_SUM;
                w.tx_sel = tx;
                w.ty_sel = ty;
            end
            1: w.alu_op = A_ABS;
            2:
            begin
                w.mul_a = MA_MAGLO;
                w.mul_b = MB_RPM;
            end
            3:
            begin
                w.shr_dst = D_SC;
                w.shr_sh = SH_FRAC;
                w.mul_a = MA_MAGHI;
                w.mul_b = MB_RPM;
            end
            default: w.alu_op = A_SAT;
        endcase
        return w;
    endfunction

    function automatic owk_ctrl_t owk_prog(input logic [PC_W-1:0] pc);
        owk_ctrl_t w;
        w = CW_NOP;
        unique case (pc)
            PC_W'(0):  w = cw(MA_ACCEL, MB_DT, D_NONE, SH_DTX, A_NOP, J_NEXT);
            PC_W'(1):  w = cw(MA_ACCEL, MB_DT5, D_STEPX, SH_DTX, A_NOP, J_NEXT);
            PC_W'(2):  w = cw(MA_TWZ, MB_RADIUS, D_STEPY, SH_DTY, A_NOP, J_NEXT);
            PC_W'(3):
            begin
                w = cw(MA_NONE, MB_DT, D_WR, SH_FRAC, A_SLEWX, J_THREE);
                w.target = PC_THREE;
            end
            PC_W'(4):  w = cw(MA_LVX, MB_COS45, D_NONE, SH_K, A_SLEWY, J_NEXT);
            PC_W'(5):  w = cw(MA_LVY, MB_COS45, D_TX, SH_K, A_NOP, J_NEXT);
            PC_W'(6):  w = cw(MA_NONE, MB_DT, D_TY, SH_K, A_NOP, J_NEXT);
            PC_W'(7):  w = owk_wheel(0, 2'd0, T_ADD, T_SUB);
            PC_W'(8):  w = owk_wheel(1, 2'd0, T_ADD, T_SUB);
            PC_W'(9):  w = owk_wheel(2, 2'd0, T_ADD, T_SUB);
            PC_W'(10): w = owk_wheel(3, 2'd0, T_ADD, T_SUB);
            PC_W'(11): w = owk_wheel(4, 2'd0, T_ADD, T_SUB);
            PC_W'(12): w = owk_wheel(0, 2'd1, T_SUB, T_SUB);
            PC_W'(13): w = owk_wheel(1, 2'd1, T_SUB, T_SUB);
            PC_W'(14): w = owk_wheel(2, 2'd1, T_SUB, T_SUB);
            PC_W'(15): w = owk_wheel(3, 2'd1, T_SUB, T_SUB);
            PC_W'(16): w = owk_wheel(4, 2'd1, T_SUB, T_SUB);
            PC_W'(17): w = owk_wheel(0, 2'd2, T_SUB, T_ADD);
            PC_W'(18): w = owk_wheel(1, 2'd2, T_SUB, T_ADD);
            PC_W'(19): w = owk_wheel(2, 2'd2, T_SUB, T_ADD);
            PC_W'(20): w = owk_wheel(3, 2'd2, T_SUB, T_ADD);
            PC_W'(21): w = owk_wheel(4, 2'd2, T_SUB, T_ADD);
            PC_W'(22): w = owk_wheel(0, 2'd3, T_ADD, T_ADD);
            PC_W'(23): w = owk_wheel(1, 2'd3, T_ADD, T_ADD);
            PC_W'(24): w = owk_wheel(2, 2'd3, T_ADD, T_ADD);
            PC_W'(25): w = owk_wheel(3, 2'd3, T_ADD, T_ADD);
            PC_W'(26): w = owk_wheel(4, 2'd3, T_ADD, T_ADD);
            PC_W'(27): w = cw(MA_NONE, MB_DT, D_NONE, SH_DTX, A_NOP, J_FIN);
            PC_W'(28): w = cw(MA_LVX, MB_COS60, D_NONE, SH_K, A_SLEWY, J_NEXT);
            PC_W'(29): w = cw(MA_LVY, MB_SIN60, D_TX, SH_K, A_NOP, J_NEXT);
            PC_W'(30):
            begin
                w = cw(MA_NONE, MB_DT, D_TY, SH_K, A_ZERO, J_NEXT);
                w.wheel = 2'd3;
            end
            PC_W'(31): w = owk_wheel(0, 2'd0, T_VX, T_OFF);
            PC_W'(32): w = owk_wheel(1, 2'd0, T_VX, T_OFF);
            PC_W'(33): w = owk_wheel(2, 2'd0, T_VX, T_OFF);
            PC_W'(34): w = owk_wheel(3, 2'd0, T_VX, T_OFF);
            PC_W'(35): w = owk_wheel(4, 2'd0, T_VX, T_OFF);
            PC_W'(36): w = owk_wheel(0, 2'd1, T_SUB, T_SUB);
            PC_W'(37): w = owk_wheel(1, 2'd1, T_SUB, T_SUB);
            PC_W'(38): w = owk_wheel(2, 2'd1, T_SUB, T_SUB);
            PC_W'(39): w = owk_wheel(3, 2'd1, T_SUB, T_SUB);
            PC_W'(40): w = owk_wheel(4, 2'd1, T_SUB, T_SUB);
            PC_W'(41): w = owk_wheel(0, 2'd2, T_SUB, T_ADD);
            PC_W'(42): w = owk_wheel(1, 2'd2, T_SUB, T_ADD);
            PC_W'(43): w = owk_wheel(2, 2'd2, T_SUB, T_ADD);
            PC_W'(44): w = owk_wheel(3, 2'd2, T_SUB, T_ADD);
            PC_W'(45): w = owk_wheel(4, 2'd2, T_SUB, T_ADD);
            default:   w = cw(MA_NONE, MB_DT, D_NONE, SH_DTX, A_NOP, J_FIN);
        endcase
        return w;
    endfunction

endpackage

[rtl/omni_wheel_kinematics_ramp_core.sv]
// One control word per cycle through a single shared multiplier; three-wheel mode runs
// a shorter program than four-wheel mode. A new input beat is accepted only once the
// program of the last beat has finished; a full result register holds the sequencer on
// its last step. Reset clears the sequencer, the result valid flag and the last
// velocities to zero and loads the configuration registers with their defaults.
// Depends on owk_pkg, owk_sequencer and owk_datapath.
module omni_wheel_kinematics_ramp_core #(
    parameter int FRAC_BITS = owk_pkg::DEF_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // target_vx, target_vy, target_wz, time_step
    input  logic [owk_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // wheel0_rpm, wheel1_rpm, wheel2_rpm, wheel3_rpm
    output logic [owk_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [owk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [owk_pkg::CFG_DATA_W-1:0] cfg_data
);
    import owk_pkg::*;

    localparam logic [30:0] ACCEL_RST = 31'(64'd1 << FRAC_BITS);
    localparam logic [30:0] RADIUS_RST = 31'((64'd2 << FRAC_BITS) / 5);
    localparam logic [30:0] RPM_RST = 31'(64'd1 << FRAC_BITS);

    logic [30:0] accel_reg, accel_next;
    logic [30:0] radius_reg, radius_next;
    logic [30:0] rpm_reg, rpm_next;
    logic        mode_reg, mode_next;
    owk_seq_t    seq;
    logic        out_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        accel_next = accel_reg;
        radius_next = radius_reg;
        rpm_next = rpm_reg;
        mode_next = mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ACCEL:  accel_next = cfg_data[30:0];
                CFG_RADIUS: radius_next = cfg_data[30:0];
                CFG_RPM:    rpm_next = cfg_data[30:0];
                CFG_MODE:   mode_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= ACCEL_RST;
            radius_reg <= RADIUS_RST;
            rpm_reg <= RPM_RST;
            mode_reg <= 1'b1;
        end
        else
        begin
            accel_reg <= accel_next;
            radius_reg <= radius_next;
            rpm_reg <= rpm_next;
            mode_reg <= mode_next;
        end
    end

    owk_sequencer u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .four_wheel_mode (mode_reg),
        .out_free        (out_free),
        .seq             (seq)
    );

    owk_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .seq            (seq),
        .in_data        (s_axis_tdata),
        .accel_limit    (accel_reg),
        .center_dist    (radius_reg),
        .rpm_scale      (rpm_reg),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .out_free       (out_free)
    );

endmodule

[rtl/owk_sequencer.sv]
// Step counter and jump logic of the omni-wheel kinematics core.
// Reads control words from the program in owk_pkg and hands them to owk_datapath.
// Depends on owk_pkg.
module owk_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic              four_wheel_mode,
    input  logic              out_free,
    output owk_pkg::owk_seq_t seq
);
    import owk_pkg::*;

    logic            busy_reg;
    logic            busy_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    owk_ctrl_t       word;
    logic            accept;
    logic            fin;

    assign word = owk_prog(pc_reg);
    assign s_axis_tready = !busy_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next = pc_reg;
        fin = 1'b0;
        if (!busy_reg)
        begin
            if (accept)
            begin
                busy_next = 1'b1;
                pc_next = '0;
            end
        end
        else
        begin
            unique case (word.jmp)
                J_FIN:
                begin
                    if (out_free)
                    begin
                        busy_next = 1'b0;
                        fin = 1'b1;
                    end
                end
                J_THREE: pc_next = four_wheel_mode ? pc_reg + 1'b1 : word.target;
                default: pc_next = pc_reg + 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg <= pc_next;
        end
    end

    assign seq.run = busy_reg;
    assign seq.load = accept;
    assign seq.fin = fin;
    assign seq.ctrl = word;

`ifndef NO_ASSERTIONS
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg < PC_W'(PROG_LEN))
        else $error("step counter left the program");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && pc_reg == '0)
        else $error("accepted beat did not start the program");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && word.jmp == J_FIN && !out_free |=> busy_reg && $stable(pc_reg))
        else $error("program finished while the result register was full");
    a_three: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && word.jmp == J_THREE && !four_wheel_mode |=> pc_reg == PC_THREE)
        else $error("three-wheel branch not taken");
`endif

endmodule

[rtl/owk_datapath.sv]
// Shared multiplier, shifter and adder datapath of the omni-wheel kinematics core.
// Executes the control words from owk_sequencer and holds the result register.
// Depends on owk_pkg.
module owk_datapath #(
    parameter int FRAC_BITS = owk_pkg::DEF_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  owk_pkg::owk_seq_t         seq,
    input  logic [owk_pkg::IN_W-1:0]  in_data,
    input  logic [30:0]               accel_limit,
    input  logic [30:0]               center_dist,
    input  logic [30:0]               rpm_scale,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [owk_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                      out_free
);
    import owk_pkg::*;

    localparam int ACC_W = 64 - FRAC_BITS;
    localparam int SC_W = 63 - FRAC_BITS;

    logic signed [31:0]      tvx_reg, tvx_next;
    logic signed [31:0]      tvy_reg, tvy_next;
    logic signed [31:0]      twz_reg, twz_next;
    logic [15:0]             dt_reg, dt_next;
    logic signed [31:0]      lvx_reg, lvx_next;
    logic signed [31:0]      lvy_reg, lvy_next;
    logic [STEP_W-1:0]       stepx_reg, stepx_next;
    logic [STEP_W-1:0]       stepy_reg, stepy_next;
    logic signed [ACC_W-1:0] wr_reg, wr_next;
    logic signed [31:0]      tx_reg, tx_next;
    logic signed [31:0]      ty_reg, ty_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-2:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [63:0]             prod_reg, prod_next;
    logic                    pneg_reg, pneg_next;
    logic [SC_W-1:0]         sc_reg, sc_next;
    logic [31:0]             res_reg [4];
    logic [31:0]             res_next [4];
    logic [OUT_W-1:0]        out_reg, out_next;
    logic                    valid_reg, valid_next;

    logic [31:0]             mul_a_v;
    logic                    mul_a_neg;
    logic [31:0]             mul_b_v;
    logic [63:0]             shifted;
    logic [63:0]             sres;
    logic signed [31:0]      sl_t;
    logic signed [31:0]      sl_l;
    logic [STEP_W-1:0]       sl_step;
    logic signed [34:0]      sl_te;
    logic signed [34:0]      sl_up;
    logic signed [34:0]      sl_dn;
    logic signed [31:0]      sl_n;
    logic signed [ACC_W-1:0] tx_term;
    logic signed [ACC_W-1:0] ty_term;
    logic signed [ACC_W-1:0] acc_abs;
    logic                    sat_hi;
    logic [30:0]             hp_sh;
    logic [SC_W:0]           r_sum;
    logic [31:0]             lim;
    logic [31:0]             rmag;

    always_comb
    begin
        mul_a_v = '0;
        mul_a_neg = 1'b0;
        unique case (seq.ctrl.mul_a)
            MA_ACCEL: mul_a_v = {1'b0, accel_limit};
            MA_TWZ:
            begin
                mul_a_neg = twz_reg[31];
                mul_a_v = twz_reg[31] ? 32'(-twz_reg) : 32'(twz_reg);
            end
            MA_LVX:
            begin
                mul_a_neg = lvx_reg[31];
                mul_a_v = lvx_reg[31] ? 32'(-lvx_reg) : 32'(lvx_reg);
            end
            MA_LVY:
            begin
                mul_a_neg = lvy_reg[31];
                mul_a_v = lvy_reg[31] ? 32'(-lvy_reg) : 32'(lvy_reg);
            end
            MA_MAGLO: mul_a_v = mag_reg[31:0];
            MA_MAGHI: mul_a_v = 32'(mag_reg[ACC_W-2:32]);
            default: mul_a_v = '0;
        endcase
    end

    always_comb
    begin
        unique case (seq.ctrl.mul_b)
            MB_DT:     mul_b_v = 32'(dt_reg);
            MB_DT5:    mul_b_v = 32'({dt_reg, 2'b00}) + 32'(dt_reg);
            MB_RADIUS: mul_b_v = {1'b0, center_dist};
            MB_COS45:  mul_b_v = 32'(K_COS45);
            MB_SIN60:  mul_b_v = 32'(K_SIN60);
            MB_COS60:  mul_b_v = 32'(K_COS60);
            MB_RPM:    mul_b_v = {1'b0, rpm_scale};
            default:   mul_b_v = '0;
        endcase
    end

    always_comb
    begin
        unique case (seq.ctrl.shr_sh)
            SH_DTX:  shifted = prod_reg >> (DT_FRAC - 1);
            SH_DTY:  shifted = prod_reg >> (DT_FRAC + 1);
            SH_FRAC: shifted = prod_reg >> FRAC_BITS;
            default: shifted = prod_reg >> K_SHIFT;
        endcase
        sres = pneg_reg ? -shifted : shifted;
    end

    // Slew limit: a command growing away from zero moves at most one step and stops at
    // its target; any other command is taken as it is.
    always_comb
    begin
        if (seq.ctrl.alu_op == A_SLEWY)
        begin
            sl_t = tvy_reg;
            sl_l = lvy_reg;
            sl_step = stepy_reg;
        end
        else
        begin
            sl_t = tvx_reg;
            sl_l = lvx_reg;
            sl_step = stepx_reg;
        end
        sl_te = 35'(sl_t);
        sl_up = 35'(sl_l) + $signed({2'b00, sl_step});
        sl_dn = 35'(sl_l) - $signed({2'b00, sl_step});
        if (sl_t > 32'sd0 && sl_t >= sl_l)
        begin
            sl_n = (sl_up > sl_te) ? sl_t : sl_up[31:0];
        end
        else if (sl_t < 32'sd0 && sl_t <= sl_l)
        begin
            sl_n = (sl_dn < sl_te) ? sl_t : sl_dn[31:0];
        end
        else
        begin
            sl_n = sl_t;
        end
    end

    always_comb
    begin
        unique case (seq.ctrl.tx_sel)
            T_ADD:   tx_term = ACC_W'(tx_reg);
            T_SUB:   tx_term = -ACC_W'(tx_reg);
            T_VX:    tx_term = ACC_W'(lvx_reg);
            default: tx_term = '0;
        endcase
        unique case (seq.ctrl.ty_sel)
            T_ADD:   ty_term = ACC_W'(ty_reg);
            T_SUB:   ty_term = -ACC_W'(ty_reg);
            default: ty_term = '0;
        endcase
        acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    end

    // Scaling: the high partial product alone decides saturation once it reaches the
    // sign position after alignment; otherwise the aligned sum is compared with the limit.
    always_comb
    begin
        sat_hi = |prod_reg[63:FRAC_BITS-1];
        hp_sh = {prod_reg[FRAC_BITS-2:0], {(32 - FRAC_BITS){1'b0}}};
        r_sum = (SC_W + 1)'(hp_sh) + (SC_W + 1)'(sc_reg);
        lim = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        rmag = (sat_hi || r_sum > (SC_W + 1)'(lim)) ? lim : r_sum[31:0];
    end

    always_comb
    begin
        tvx_next = tvx_reg;
        tvy_next = tvy_reg;
        twz_next = twz_reg;
        dt_next = dt_reg;
        lvx_next = lvx_reg;
        lvy_next = lvy_reg;
        stepx_next = stepx_reg;
        stepy_next = stepy_reg;
        wr_next = wr_reg;
        tx_next = tx_reg;
        ty_next = ty_reg;
        acc_next = acc_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        prod_next = prod_reg;
        pneg_next = pneg_reg;
        sc_next = sc_reg;
        res_next = res_reg;
        out_next = out_reg;
        valid_next = valid_reg && !m_axis_tready;

        if (seq.load)
        begin
            tvx_next = in_data[31:0];
            tvy_next = in_data[63:32];
            twz_next = in_data[95:64];
            dt_next = in_data[111:96];
        end

        if (seq.run)
        begin
            if (seq.ctrl.mul_a != MA_NONE)
            begin
                prod_next = mul_a_v * mul_b_v;
                pneg_next = mul_a_neg;
            end

            unique case (seq.ctrl.shr_dst)
                D_STEPX: stepx_next = shifted[STEP_W-1:0];
                D_STEPY: stepy_next = shifted[STEP_W-1:0];
                D_WR:    wr_next = sres[ACC_W-1:0];
                D_TX:    tx_next = sres[31:0];
                D_TY:    ty_next = sres[31:0];
                D_SC:    sc_next = shifted[SC_W-1:0];
                default: ;
            endcase

            unique case (seq.ctrl.alu_op)
                A_SLEWX: lvx_next = sl_n;
                A_SLEWY: lvy_next = sl_n;
                A_SUM:   acc_next = wr_reg + tx_term + ty_term;
                A_ABS:
                begin
                    neg_next = acc_reg[ACC_W-1];
                    mag_next = acc_abs[ACC_W-2:0];
                end
                A_SAT:   res_next[seq.ctrl.wheel] = neg_reg ? -rmag : rmag;
                A_ZERO:  res_next[seq.ctrl.wheel] = '0;
                default: ;
            endcase
        end

        if (seq.fin)
        begin
            out_next = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lvx_reg <= '0;
            lvy_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            lvx_reg <= lvx_next;
            lvy_reg <= lvy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tvx_reg <= tvx_next;
        tvy_reg <= tvy_next;
        twz_reg <= twz_next;
        dt_reg <= dt_next;
        stepx_reg <= stepx_next;
        stepy_reg <= stepy_next;
        wr_reg <= wr_next;
        tx_reg <= tx_next;
        ty_reg <= ty_next;
        acc_reg <= acc_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        prod_reg <= prod_next;
        pneg_reg <= pneg_next;
        sc_reg <= sc_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata = out_reg;
    assign out_free = !valid_reg || m_axis_tready;

endmodule

[verif/omni_wheel_kinematics_ramp_checker.sv]
// Checker for the omni-wheel kinematics core: watches the command, result and register
// channels, predicts the wheel speeds of every accepted command and compares them.
// Depends on owk_pkg.
module omni_wheel_kinematics_ramp_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [owk_pkg::IN_W-1:0]       s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [owk_pkg::OUT_W-1:0]      m_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [owk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [owk_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           finish_req,
    output int                             pending,
    output int                             errors,
    output int                             checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import owk_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;

    typedef struct packed {
        logic        [15:0] dt;
        logic signed [31:0] wz;
        logic signed [31:0] vy;
        logic signed [31:0] vx;
    } chassis_cmd_t;

    typedef logic [3:0][31:0] wheel_rpm_t;

    logic [30:0] accel_lim;
    logic [30:0] radius;
    logic [30:0] rpm_gain;
    logic        four_wheel;
    longint      prev_vx;
    longint      prev_vy;
    bit          drained;
    wheel_rpm_t  wheel_rpm_q[$];

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 50)
        begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    function automatic longint trunc_mul(input longint x, input longint c, input int sh);
        longint p;
        p = x * c;
        if (p < 0)
        begin
            return -((-p) >> sh);
        end
        return p >> sh;
    endfunction

    function automatic longint slew_axis(input longint tgt, input longint prev,
                                         input longint step);
        longint n;
        if (tgt > 0 && tgt >= prev)
        begin
            n = prev + step;
            if (n > tgt)
            begin
                n = tgt;
            end
        end
        else if (tgt < 0 && tgt <= prev)
        begin
            n = prev - step;
            if (n < tgt)
            begin
                n = tgt;
            end
        end
        else
        begin
            n = tgt;
        end
        return n;
    endfunction

    function automatic logic [31:0] scale_rpm(input longint sum);
        logic        neg;
        logic [63:0] mag;
        logic [95:0] prod;
        logic [95:0] lim;
        neg = sum < 0;
        mag = neg ? 64'(-sum) : 64'(sum);
        prod = (96'(mag) * 96'(rpm_gain)) >> FRAC;
        lim = neg ? 96'h8000_0000 : 96'h7FFF_FFFF;
        if (prod > lim)
        begin
            prod = lim;
        end
        return neg ? -prod[31:0] : prod[31:0];
    endfunction

    // Advances the last velocities as a side effect, once per accepted command.
    function automatic wheel_rpm_t predict_wheels(input chassis_cmd_t cmd);
        logic [47:0] acc_dt;
        longint      stx;
        longint      sty;
        longint      vx;
        longint      vy;
        longint      wr;
        longint      a;
        longint      b;
        longint      sum[4];
        wheel_rpm_t  w;
        acc_dt = 48'(accel_lim) * 48'(cmd.dt);
        stx = longint'((64'(acc_dt) << 1) >> DT_FRAC);
        sty = longint'((64'(acc_dt) * 64'd5) >> (DT_FRAC + 1));
        vx = slew_axis(longint'(cmd.vx), prev_vx, stx);
        vy = slew_axis(longint'(cmd.vy), prev_vy, sty);
        prev_vx = vx;
        prev_vy = vy;
        wr = trunc_mul(longint'(cmd.wz), longint'(radius), FRAC);
        if (four_wheel)
        begin
            a = trunc_mul(vx, longint'(K_COS45), K_SHIFT);
            b = trunc_mul(vy, longint'(K_COS45), K_SHIFT);
            sum[0] = -b + a + wr;
            sum[1] = -b - a + wr;
            sum[2] = b - a + wr;
            sum[3] = b + a + wr;
            w[3] = scale_rpm(sum[3]);
        end
        else
        begin
            sum[0] = vx + wr;
            sum[1] = -trunc_mul(vy, longint'(K_SIN60), K_SHIFT)
                     - trunc_mul(vx, longint'(K_COS60), K_SHIFT) + wr;
            sum[2] = trunc_mul(vy, longint'(K_SIN60), K_SHIFT)
                     - trunc_mul(vx, longint'(K_COS60), K_SHIFT) + wr;
            w[3] = '0;
        end
        w[0] = scale_rpm(sum[0]);
        w[1] = scale_rpm(sum[1]);
        w[2] = scale_rpm(sum[2]);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        wheel_rpm_t exp_w;
        wheel_rpm_t got;
        if (!rst_n)
        begin
            accel_lim = 31'd65536;
            radius = 31'd26214;
            rpm_gain = 31'd65536;
            four_wheel = 1'b1;
            prev_vx = 0;
            prev_vy = 0;
            drained = 1'b0;
            wheel_rpm_q.delete();
            errors = 0;
            checked <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ACCEL:  accel_lim = cfg_data[30:0];
                    CFG_RADIUS: radius = cfg_data[30:0];
                    CFG_RPM:    rpm_gain = cfg_data[30:0];
                    CFG_MODE:   four_wheel = cfg_data[0];
                    default:    ;
                endcase
            end
            if (s_valid && s_ready)
            begin
                wheel_rpm_q.push_back(predict_wheels(chassis_cmd_t'(s_data)));
            end
            if (m_valid && m_ready)
            begin
                got = wheel_rpm_t'(m_data);
                if (wheel_rpm_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %h with no command pending", got));
                end
                else
                begin
                    exp_w = wheel_rpm_q.pop_front();
                    for (int k = 0; k < 4; k++)
                    begin
                        if (got[k] !== exp_w[k])
                        begin
                            report_mismatch($sformatf("wheel%0d_rpm got %h expected %h",
                                                      k, got[k], exp_w[k]));
                        end
                    end
                    checked <= checked + 1;
                end
            end
            if (finish_req && !drained)
            begin
                drained = 1'b1;
                while (wheel_rpm_q.size() > 0)
                begin
                    wheel_rpm_q.delete(0);
                    report_mismatch("expected result never arrived");
                end
            end
            pending <= wheel_rpm_q.size();
        end
    end

endmodule

[verif/tb_omni_wheel_kinematics_ramp_core.sv]
// Testbench top for omni_wheel_kinematics_ramp_core: drives chassis commands and register
// writes with random idling, a long output stall, and gives the verdict.
// Depends on owk_pkg, the core and omni_wheel_kinematics_ramp_checker.
module tb_omni_wheel_kinematics_ramp_core;
    timeunit 1ns;
    timeprecision 1ps;

    import owk_pkg::*;

    localparam logic [31:0] V_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] V_MIN = 32'h8000_0000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = '1;
    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int STALL_AFTER = 300;
    localparam int STALL_CYCLES = 600;
    localparam int PHASES = 8;
    localparam int PHASE_CMDS = 230;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  finish_req = 1'b0;
    int                    pending;
    int                    errors;
    int                    checked;
    bit                    burst = 1'b0;
    int                    sent = 0;
    int                    results = 0;
    int                    settings = 0;
    int                    idle_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    omni_wheel_kinematics_ramp_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    omni_wheel_kinematics_ramp_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_data     (m_axis_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .finish_req (finish_req),
        .pending    (pending),
        .errors     (errors),
        .checked    (checked)
    );

    function automatic logic [31:0] rand_velocity();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       return V_MAX;
                    1:       return V_MIN;
                    2:       return 32'd0;
                    3:       return 32'd1;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                mag = $urandom_range(0, 1 << $urandom_range(4, 22));
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic logic [31:0] rand_reg();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(1 << 12, 1 << 18);
        endcase
    endfunction

    task automatic send_cmd(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] wz, input logic [15:0] dt);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {dt, wz, vy, vx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic directed_checks();
        send_cmd(32'd0, 32'd0, 32'd0, 16'd0);
        send_cmd(V_MAX, V_MAX, 32'd0, 16'hFFFF);
        send_cmd(V_MAX, V_MAX, V_MAX, 16'd0);
        send_cmd(V_MIN, V_MIN, V_MIN, 16'hFFFF);
        send_cmd(V_MIN, V_MIN, V_MIN, 16'hFFFF);
        send_cmd(32'hFFFF_0000, 32'h0001_0000, 32'd0, 16'd100);
        send_cmd(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 16'd1);
        wait_for_drain();
        write_reg(CFG_ACCEL, 32'd0);
        send_cmd(V_MAX, V_MIN, V_MAX, 16'hFFFF);
        send_cmd(V_MAX, V_MIN, V_MIN, 16'hFFFF);
        wait_for_drain();
        write_reg(CFG_ACCEL, 32'hFFFF_FFFF);
        write_reg(CFG_RPM, 32'hFFFF_FFFF);
        send_cmd(V_MAX, V_MIN, V_MAX, 16'hFFFF);
        send_cmd(V_MIN, V_MAX, V_MIN, 16'hFFFF);
        send_cmd(V_MAX, V_MAX, V_MAX, 16'h8000);
        wait_for_drain();
        write_reg(CFG_UNUSED, 32'd0);
        write_reg(CFG_UNUSED_TOP, 32'hFFFF_FFFF);
        write_reg(CFG_MODE, 32'hFFFF_FFFE);
        write_reg(CFG_RADIUS, 32'hFFFF_FFFF);
        send_cmd(V_MIN, V_MAX, V_MAX, 16'hFFFF);
        send_cmd(V_MAX, V_MIN, V_MIN, 16'hFFFF);
        send_cmd(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, 16'd655);
        wait_for_drain();
        write_reg(CFG_RPM, 32'd0);
        send_cmd(V_MAX, V_MAX, V_MAX, 16'hFFFF);
        wait_for_drain();
        write_reg(CFG_RPM, 32'h0001_0000);
        write_reg(CFG_RADIUS, 32'd26214);
        write_reg(CFG_MODE, 32'd1);
        send_cmd(32'h0001_8000, 32'hFFFF_4000, 32'h0003_0000, 16'd0);
        send_cmd(32'h0001_8000, 32'hFFFF_4000, 32'h0003_0000, 16'd1000);
        wait_for_drain();
        settings += 6;
    endtask

    task automatic apply_setting(input int phase);
        logic [31:0] acc;
        logic [31:0] rad;
        logic [31:0] rpm;
        logic [31:0] mode;
        case (phase)
            1:
            begin
                acc = 32'hFFFF_FFFF;
                rad = 32'h7FFF_FFFF;
                rpm = 32'h7FFF_FFFF;
                mode = 32'd1;
            end
            2:
            begin
                acc = 32'd0;
                rad = 32'd0;
                rpm = 32'h0001_0000;
                mode = 32'd0;
            end
            default:
            begin
                acc = rand_reg();
                rad = rand_reg();
                rpm = rand_reg();
                mode = $urandom;
                mode[0] = phase[0];
            end
        endcase
        if ($urandom_range(0, 1))
        begin
            write_reg(CFG_UNUSED, $urandom);
        end
        write_reg(CFG_ACCEL, acc);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_RPM, rpm);
        write_reg(CFG_MODE, mode);
        settings++;
    endtask

    // Most commands come as runs that hold one target, so the ramp climbs and clamps.
    task automatic random_commands(input int count);
        int          left;
        int          run;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] wz;
        left = count;
        while (left > 0)
        begin
            vx = rand_velocity();
            vy = rand_velocity();
            wz = rand_velocity();
            run = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
            for (int i = 0; i < run && left > 0; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    wz = rand_velocity();
                end
                send_cmd(vx, vy, wz, rand_dt());
                left--;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_checks();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            burst = (phase == 3);
            apply_setting(phase);
            random_commands(PHASE_CMDS);
            wait_for_drain();
        end
        finish_req <= 1'b1;
        repeat (3) @(posedge clk);
        $display("Covered %0d commands and %0d checked results over %0d register settings,",
                 sent, checked, settings);
        $display("both wheel layouts, ramp clamps, saturation and a long output stall.");
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Result side: random hold-off per beat, and one long stall that backs up the core.
    initial
    begin : result_sink
        int hold;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            hold = burst ? 0 : $urandom_range(0, 8);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            results++;
            if (results == STALL_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d cycles without a beat", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

[filelist.f]
rtl/owk_pkg.sv
rtl/owk_sequencer.sv
rtl/owk_datapath.sv
rtl/omni_wheel_kinematics_ramp_core.sv
verif/omni_wheel_kinematics_ramp_checker.sv
verif/tb_omni_wheel_kinematics_ramp_core.sv
